>>> hdl/nceg_pkg.sv
// ----------------------------------------------------------------------------
// nceg_pkg
// Types and codes shared by the note change event generator and its checker.
// ----------------------------------------------------------------------------
package nceg_pkg;

	localparam logic [1:0] OP_ROW   = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic EV_NOTE_ON  = 1'b0;
	localparam logic EV_OFF_MASK = 1'b1;

	// 127 in Q4: t = NOTE_TOP_Q4 - row_position
	localparam logic signed [17:0] NOTE_TOP_Q4 = 18'sd2032;
	localparam logic signed [17:0] T_MIN       = -18'sd15;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [4:0]         channel;
		logic signed [15:0] row_position;
		logic [6:0]         velocity;
	} item_t;

	typedef struct packed {
		logic        event_kind;
		logic [4:0]  out_channel;
		logic [6:0]  note;
		logic [6:0]  out_velocity;
		logic        mask_half;
		logic [63:0] off_mask;
		logic        last;
	} result_t;

endpackage

>>> hdl/note_change_event_generator_top.sv
// ----------------------------------------------------------------------------
// note_change_event_generator_top
// Note-on events and note-off masks from per-tick row items.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle while the result register drains. A row
// item reads its channel's previous frame from a synchronous memory (one row
// per channel) and gives at most one note-on; an end item gives two mask
// results, so it holds the input until both are sent, and writes the frame
// back as it retires. A write that lands on the row the next item reads is
// forwarded. A clear item takes effect at once through per-channel valid bits,
// with no clearing pass.
module note_change_event_generator_top
	import nceg_pkg::*;
#(
	parameter int CHANNEL_COUNT = 16,
	parameter int NOTE_COUNT    = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int NI = $clog2(NOTE_COUNT);

	logic [NOTE_COUNT-1:0] mem [CHANNEL_COUNT];
	logic [NOTE_COUNT-1:0] mem_rd_q;
	logic [CHANNEL_COUNT-1:0] valid_q;
	logic [NOTE_COUNT-1:0] frame_q;

	logic                  s1_v, s1_half;
	logic                  s1_end;
	logic [4:0]            s1_ch;
	logic [AW-1:0]         s1_row;
	logic [6:0]            s1_note, s1_vel;
	logic [NOTE_COUNT-1:0] s1_snap, s1_fwd_data;
	logic                  s1_fwd, s1_vld;

	logic    out_v_q;
	result_t out_q;

	// input decode
	logic                 acc, ch_ok, keep, s1_load;
	logic signed [17:0]   t_s0;
	logic [13:0]          note_full;
	logic [6:0]           note_s0;
	logic [AW-1:0]        row_s0;

	always_comb begin
		ch_ok     = (item.channel >= 5'd1) && (item.channel <= 5'(CHANNEL_COUNT));
		row_s0    = AW'(item.channel - 5'd1);
		t_s0      = NOTE_TOP_Q4 - 18'(item.row_position);
		note_full = t_s0[17] ? 14'd0 : t_s0[17:4];
		note_s0   = note_full[6:0];
		keep      = ch_ok && (t_s0 >= T_MIN) && (note_full < 14'(NOTE_COUNT));
	end

	// stage 1 evaluation
	logic [NOTE_COUNT-1:0] prev;
	logic [127:0]          prev_w, snap_w;
	logic                  emit, out_free, s1_push, s1_retire;
	result_t               res_n;

	always_comb begin
		prev     = s1_fwd ? s1_fwd_data : (s1_vld ? mem_rd_q : '0);
		prev_w   = 128'(prev);
		snap_w   = 128'(s1_snap);
		emit     = s1_end || !prev_w[s1_note];
		out_free = !out_v_q || result_ready;
		s1_push  = s1_v && emit && out_free;
		if (s1_end)
			s1_retire = s1_v && s1_half && out_free;
		else
			s1_retire = s1_v && (!emit || out_free);
		item_ready = !s1_v || s1_retire;
		acc        = item_valid && item_ready;
		s1_load    = acc && (((item.opcode == OP_ROW) && keep) ||
			((item.opcode == OP_END) && ch_ok));

		res_n = '0;
		res_n.out_channel = s1_ch;
		if (s1_end) begin
			res_n.event_kind = EV_OFF_MASK;
			res_n.mask_half  = s1_half;
			res_n.last       = s1_half;
			res_n.off_mask   = s1_half ? (prev_w[127:64] & ~snap_w[127:64])
				: (prev_w[63:0] & ~snap_w[63:0]);
		end else begin
			res_n.event_kind   = EV_NOTE_ON;
			res_n.note         = s1_note;
			res_n.out_velocity = s1_vel;
			res_n.last         = 1'b1;
		end
	end

	// memory: read at accept, write back as an end item retires
	always_ff @(posedge clk) begin
		if (acc && ch_ok)
			mem_rd_q <= mem[row_s0];
		if (s1_retire && s1_end)
			mem[s1_row] <= s1_snap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			frame_q <= '0;
			s1_v    <= 1'b0;
			s1_half <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			// a clear taken as an end item retires comes after it
			if (acc && (item.opcode == OP_CLEAR))
				valid_q <= '0;
			else if (s1_retire && s1_end)
				valid_q[s1_row] <= 1'b1;
			if (acc) begin
				unique case (item.opcode)
					OP_ROW: begin
						if (keep)
							frame_q[note_s0[NI-1:0]] <= 1'b1;
					end
					OP_END: frame_q <= '0;
					OP_CLEAR: frame_q <= '0;
					default: ;
				endcase
			end

			if (s1_load) begin
				s1_v    <= 1'b1;
				s1_half <= 1'b0;
			end else if (s1_retire) begin
				s1_v <= 1'b0;
			end else if (s1_push && s1_end) begin
				s1_half <= 1'b1;
			end

			if (s1_push)
				out_v_q <= 1'b1;
			else if (result_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			s1_end      <= (item.opcode == OP_END);
			s1_ch       <= item.channel;
			s1_row      <= row_s0;
			s1_note     <= note_s0;
			s1_vel      <= item.velocity;
			s1_snap     <= frame_q;
			s1_vld      <= valid_q[row_s0];
			// end item writing this row at the same edge
			s1_fwd      <= s1_v && s1_end && s1_retire && (s1_row == row_s0);
			s1_fwd_data <= s1_snap;
		end
		if (s1_push)
			out_q <= res_n;
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

>>> hdl/nceg_checker.sv
// ----------------------------------------------------------------------------
// nceg_checker
// Port-level checks for the note change event generator.
// ----------------------------------------------------------------------------
module nceg_checker
	import nceg_pkg::*;
#(
	parameter int CHANNEL_COUNT = 16
) (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_note_on_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_kind == EV_NOTE_ON) |->
			result.last && !result.mask_half && (result.off_mask == 64'd0))
		else $error("malformed note-on");

	a_mask_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_kind == EV_OFF_MASK) |->
			(result.last == result.mask_half) && (result.note == 7'd0))
		else $error("mask half and last disagree");

	// upper half follows the lower half directly, on the same channel
	a_mask_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && (result.event_kind == EV_OFF_MASK) &&
			!result.mask_half |=>
			result_valid && (result.event_kind == EV_OFF_MASK) && result.mask_half &&
			(result.out_channel == $past(result.out_channel)))
		else $error("upper mask half missing");

	a_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.out_channel >= 5'd1) &&
			(result.out_channel <= 5'(CHANNEL_COUNT)))
		else $error("result channel out of range");

endmodule

bind note_change_event_generator_top nceg_checker #(
	.CHANNEL_COUNT(CHANNEL_COUNT)
) u_nceg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
